[hw/rtl/q24_8_fixed_point_alu_defines.svh]
// Shared assertion macros for the Q24.8 ALU
`ifndef Q24_8_FIXED_POINT_ALU_DEFINES_SVH
`define Q24_8_FIXED_POINT_ALU_DEFINES_SVH

// Same-cycle implication
`define QFX_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qfx assertion failed");

// Next-cycle implication
`define QFX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qfx assertion failed");

`endif

[hw/rtl/qfx_pkg.sv]
// ----------------------------------------------------------------------------
// qfx_pkg
// Types, constants and helpers shared by the Q24.8 ALU pipeline.
// ----------------------------------------------------------------------------
package qfx_pkg;

  localparam int FRAC_BITS = 8;
  localparam int NUM_W     = 32 + FRAC_BITS;  // dividend bits, one cell each
  localparam int PROD_W    = 64;

  localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MIN_NEG = 32'h8000_0000;

  typedef enum logic [3:0] {
    OP_ADD      = 4'd0,
    OP_SUB      = 4'd1,
    OP_MUL      = 4'd2,
    OP_DIV      = 4'd3,
    OP_MIN      = 4'd4,
    OP_MAX      = 4'd5,
    OP_INCR     = 4'd6,
    OP_DECR     = 4'd7,
    OP_TO_INT   = 4'd8,
    OP_FROM_INT = 4'd9
  } op_e;

  typedef struct packed {
    op_e                op;
    logic               neg;   // sign of mul/div result
    logic [31:0]        res;   // final value for simple ops
    logic               ovf;
    logic               lt;
    logic               eq;
    logic               gt;
    logic               dz;
    logic [PROD_W-1:0]  prod;
    logic [31:0]        den;
    logic [NUM_W-1:0]   num;   // shifts out MSB first
    logic [NUM_W-1:0]   quo;
    logic [31:0]        rem;
  } item_t;

  // {ovf, value} from a 33-bit signed sum
  function automatic logic [32:0] sat33(input logic [32:0] v);
    logic ovf;
    logic [31:0] val;
    ovf = v[32] ^ v[31];
    val = ovf ? (v[32] ? MIN_NEG : MAX_POS) : v[31:0];
    return {ovf, val};
  endfunction

endpackage

[hw/rtl/q24_8_fixed_point_alu.sv]
// Stages: entry stage, product stage, one division cell per dividend bit,
// then the rounding/output register.
// Throughput: one transfer per cycle; the whole chain advances together and
// holds only while a result sits at the output under stall.
// Reset clears the valid bits of every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu
// Signed Q24.8 ALU built as a chain of long-division cells.
// ----------------------------------------------------------------------------
`include "q24_8_fixed_point_alu_defines.svh"

module q24_8_fixed_point_alu import qfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [3:0]  operation_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic signed [31:0] result_value_o,
  output logic        a_less_o,
  output logic        a_equal_o,
  output logic        a_greater_o,
  output logic        overflow_flag_o,
  output logic        divide_by_zero_o
);

  logic  en;
  logic  vld  [NUM_W+2];
  item_t pipe [NUM_W+2];

  assign stall_o = valid_o && stall_i;
  assign en      = !stall_o;

  qfx_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i,
    .operation_i, .operand_a_i, .operand_b_i,
    .valid_o(vld[0]), .item_o(pipe[0])
  );

  qfx_mul u_mul (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vld[0]), .item_i(pipe[0]),
    .valid_o(vld[1]), .item_o(pipe[1])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    qfx_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vld[i+1]), .item_i(pipe[i+1]),
      .valid_o(vld[i+2]), .item_o(pipe[i+2])
    );
  end

  qfx_post u_post (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(vld[NUM_W+1]), .item_i(pipe[NUM_W+1]),
    .valid_o, .result_value_o, .a_less_o, .a_equal_o, .a_greater_o,
    .overflow_flag_o, .divide_by_zero_o
  );

  `QFX_ASSERT_IMPLY(a_stall_only_when_full, clk_i, rst_ni, stall_o, valid_o)
  `QFX_ASSERT_IMPLY(a_cmp_onehot, clk_i, rst_ni, valid_o, $onehot({a_less_o, a_equal_o, a_greater_o}))
  `QFX_ASSERT_IMPLY(a_dz_no_ovf, clk_i, rst_ni, valid_o, !(divide_by_zero_o && overflow_flag_o))
  `QFX_ASSERT_NEXT(a_entry_loaded, clk_i, rst_ni, valid_i && !stall_o, vld[0])

endmodule

[hw/rtl/qfx_prep.sv]
// ----------------------------------------------------------------------------
// qfx_prep
// Entry stage: compares, simple ops, magnitudes for the mul/div chain.
// ----------------------------------------------------------------------------
module qfx_prep import qfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  logic [3:0]  operation_i,
  input  logic signed [31:0] operand_a_i,
  input  logic signed [31:0] operand_b_i,
  output logic        valid_o,
  output item_t       item_o
);

  logic              valid_q;
  item_t             item_d, item_q;
  logic [32:0]       sum_s, diff_s, inc_s, dec_s;
  logic [32:0]       sat_v;
  logic [NUM_W-1:0]  from_ext;
  logic              from_ovf;
  logic [31:0]       mag_a, mag_b;
  logic              a_lt_b;

  always_comb begin
    sum_s    = {operand_a_i[31], operand_a_i} + {operand_b_i[31], operand_b_i};
    diff_s   = {operand_a_i[31], operand_a_i} - {operand_b_i[31], operand_b_i};
    inc_s    = {operand_a_i[31], operand_a_i} + 33'd1;
    dec_s    = {operand_a_i[31], operand_a_i} - 33'd1;
    from_ext = {operand_a_i, {FRAC_BITS{1'b0}}};
    from_ovf = (from_ext[NUM_W-1:31] != {(NUM_W-31){1'b0}}) &&
               (from_ext[NUM_W-1:31] != {(NUM_W-31){1'b1}});
    mag_a    = operand_a_i[31] ? 32'(-operand_a_i) : operand_a_i;
    mag_b    = operand_b_i[31] ? 32'(-operand_b_i) : operand_b_i;
    a_lt_b   = operand_a_i < operand_b_i;

    item_d      = '0;
    item_d.op   = op_e'(operation_i);
    item_d.neg  = operand_a_i[31] ^ operand_b_i[31];
    item_d.lt   = a_lt_b;
    item_d.eq   = operand_a_i == operand_b_i;
    item_d.gt   = operand_a_i > operand_b_i;
    item_d.num  = {mag_a, {FRAC_BITS{1'b0}}};
    item_d.den  = mag_b;
    sat_v       = '0;

    unique case (item_d.op)
      OP_ADD:  sat_v = sat33(sum_s);
      OP_SUB:  sat_v = sat33(diff_s);
      OP_INCR: sat_v = sat33(inc_s);
      OP_DECR: sat_v = sat33(dec_s);
      default: sat_v = '0;
    endcase

    unique case (item_d.op)
      OP_ADD, OP_SUB, OP_INCR, OP_DECR: begin
        item_d.ovf = sat_v[32];
        item_d.res = sat_v[31:0];
      end
      OP_MIN:    item_d.res = a_lt_b ? operand_a_i : operand_b_i;
      OP_MAX:    item_d.res = a_lt_b ? operand_b_i : operand_a_i;
      OP_TO_INT: item_d.res = 32'(operand_a_i >>> FRAC_BITS);
      OP_FROM_INT: begin
        item_d.ovf = from_ovf;
        item_d.res = from_ovf ? (operand_a_i[31] ? MIN_NEG : MAX_POS) : from_ext[31:0];
      end
      OP_DIV: begin
        if (operand_b_i == 32'sd0) begin
          item_d.dz  = 1'b1;
          item_d.res = operand_a_i[31] ? MIN_NEG :
                       ((operand_a_i == 32'sd0) ? 32'd0 : MAX_POS);
        end
      end
      default: item_d.res = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/qfx_mul.sv]
// ----------------------------------------------------------------------------
// qfx_mul
// Magnitude product stage, 32x32 bits.
// ----------------------------------------------------------------------------
module qfx_mul import qfx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic  valid_q;
  item_t item_d, item_q;

  always_comb begin
    item_d      = item_i;
    item_d.prod = PROD_W'(item_i.num[NUM_W-1 -: 32] * item_i.den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/qfx_cell.sv]
// ----------------------------------------------------------------------------
// qfx_cell
// One restoring-division cell: brings down a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module qfx_cell import qfx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  valid_o,
  output item_t item_o
);

  logic        valid_q;
  item_t       item_d, item_q;
  logic [32:0] part;
  logic        fits;

  always_comb begin
    part   = {item_i.rem, item_i.num[NUM_W-1]};
    fits   = part >= {1'b0, item_i.den};
    item_d = item_i;
    item_d.rem = fits ? 32'(part - {1'b0, item_i.den}) : part[31:0];
    item_d.num = {item_i.num[NUM_W-2:0], 1'b0};
    item_d.quo = {item_i.quo[NUM_W-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[hw/rtl/qfx_post.sv]
// ----------------------------------------------------------------------------
// qfx_post
// Rounding, sign and saturation for mul/div; output register.
// ----------------------------------------------------------------------------
module qfx_post import qfx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic        valid_i,
  input  item_t       item_i,
  output logic        valid_o,
  output logic signed [31:0] result_value_o,
  output logic        a_less_o,
  output logic        a_equal_o,
  output logic        a_greater_o,
  output logic        overflow_flag_o,
  output logic        divide_by_zero_o
);

  logic              valid_q;
  logic [31:0]       res_d, res_q;
  logic              ovf_d, ovf_q;
  logic              lt_q, eq_q, gt_q, dz_q;
  logic [PROD_W-1:0] mul_mag;
  logic [NUM_W:0]    div_mag;
  logic              rnd_up;
  logic [PROD_W-1:0] mag;
  logic [PROD_W-1:0] lim;

  always_comb begin
    mul_mag = (item_i.prod + (PROD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    rnd_up  = {item_i.rem, 1'b0} >= {1'b0, item_i.den};
    div_mag = {1'b0, item_i.quo} + (NUM_W + 1)'(rnd_up);
    mag     = (item_i.op == OP_MUL) ? mul_mag : PROD_W'(div_mag);
    lim     = item_i.neg ? PROD_W'(MIN_NEG) : PROD_W'(MAX_POS);
    res_d   = item_i.res;
    ovf_d   = item_i.ovf;
    if ((item_i.op == OP_MUL) || (item_i.op == OP_DIV && !item_i.dz)) begin
      if (mag > lim) begin
        ovf_d = 1'b1;
        res_d = item_i.neg ? MIN_NEG : MAX_POS;
      end else begin
        res_d = item_i.neg ? 32'(-mag[31:0]) : mag[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      ovf_q <= ovf_d;
      lt_q  <= item_i.lt;
      eq_q  <= item_i.eq;
      gt_q  <= item_i.gt;
      dz_q  <= item_i.dz;
    end
  end

  assign valid_o          = valid_q;
  assign result_value_o   = res_q;
  assign a_less_o         = lt_q;
  assign a_equal_o        = eq_q;
  assign a_greater_o      = gt_q;
  assign overflow_flag_o  = ovf_q;
  assign divide_by_zero_o = dz_q;

endmodule

[tb/sv/q24_8_fixed_point_alu_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_test
// Drives directed and random operations into the Q24.8 ALU and checks every
// result against a predictor in the scoreboard, in order, field by field.
// ----------------------------------------------------------------------------
module q24_8_fixed_point_alu_test import qfx_pkg::*;;

  typedef struct {
    logic [31:0] value;
    logic        lt, eq, gt, ovf, dz;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors = 0;

    function automatic alu_result_t predict(logic [3:0] op, logic signed [31:0] a,
                                            logic signed [31:0] b);
      alu_result_t r;
      longint sa, sb, v;
      logic [63:0] m, num, den, q;
      logic neg;
      sa = a; sb = b;
      r.value = '0; r.ovf = 0; r.dz = 0;
      neg = (sa < 0) != (sb < 0);
      v = 0;
      case (op)
        OP_ADD:      v = sa + sb;
        OP_SUB:      v = sa - sb;
        OP_MUL: begin
          m = (sa < 0 ? -sa : sa) * (sb < 0 ? -sb : sb);
          m = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
          v = neg ? -longint'(m) : longint'(m);
        end
        OP_DIV: begin
          if (sb == 0) begin
            r.dz = 1;
            v = sa > 0 ? 64'sd2147483647 : (sa < 0 ? -64'sd2147483648 : 0);
          end else begin
            num = (sa < 0 ? -sa : sa) << FRAC_BITS;
            den = sb < 0 ? -sb : sb;
            q = (2 * num + den) / (2 * den);
            v = neg ? -longint'(q) : longint'(q);
          end
        end
        OP_MIN:      v = (sa < sb) ? sa : sb;
        OP_MAX:      v = (sa < sb) ? sb : sa;
        OP_INCR:     v = sa + 1;
        OP_DECR:     v = sa - 1;
        OP_TO_INT:   v = sa >>> FRAC_BITS;
        OP_FROM_INT: v = sa * (64'sd1 <<< FRAC_BITS);
        default:     v = 0;
      endcase
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647; r.ovf = 1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648; r.ovf = 1;
      end
      r.value = v[31:0];
      r.lt = sa < sb; r.eq = sa == sb; r.gt = sa > sb;
      return r;
    endfunction

    function void note_operation(logic [3:0] op, logic [31:0] a, logic [31:0] b);
      pending.push_back(predict(op, a, b));
    endfunction

    function void check_result(alu_result_t got);
      alu_result_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h", $time, got.value);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (exp.value !== got.value) begin
        $display("%0t: value exp %h got %h", $time, exp.value, got.value); errors++;
      end
      if (exp.lt !== got.lt) begin
        $display("%0t: a_less exp %b got %b", $time, exp.lt, got.lt); errors++;
      end
      if (exp.eq !== got.eq) begin
        $display("%0t: a_equal exp %b got %b", $time, exp.eq, got.eq); errors++;
      end
      if (exp.gt !== got.gt) begin
        $display("%0t: a_greater exp %b got %b", $time, exp.gt, got.gt); errors++;
      end
      if (exp.ovf !== got.ovf) begin
        $display("%0t: overflow exp %b got %b", $time, exp.ovf, got.ovf); errors++;
      end
      if (exp.dz !== got.dz) begin
        $display("%0t: div_by_zero exp %b got %b", $time, exp.dz, got.dz); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        valid_i = 0;
  logic        stall_o;
  logic [3:0]  operation_i = '0;
  logic signed [31:0] operand_a_i = '0;
  logic signed [31:0] operand_b_i = '0;
  logic        valid_o;
  logic        stall_i = 0;
  logic signed [31:0] result_value_o;
  logic        a_less_o, a_equal_o, a_greater_o, overflow_flag_o, divide_by_zero_o;

  alu_scoreboard board = new();
  bit          long_hold = 0;
  bit          sending_done = 0;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  q24_8_fixed_point_alu u_dut (.*);

  // transfers sampled at the edge, before the new drive values land
  always @(posedge clk_i) begin
    alu_result_t got;
    if (rst_ni && valid_o && !stall_i) begin
      got.value = result_value_o; got.lt = a_less_o; got.eq = a_equal_o;
      got.gt = a_greater_o; got.ovf = overflow_flag_o; got.dz = divide_by_zero_o;
      board.check_result(got);
    end
  end

  // receiver stall pattern, with at most one long hold-off
  initial begin
    int mode;
    int hold;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        stall_i <= 1;
        for (hold = 0; hold < 150; hold++) @(posedge clk_i);
        long_hold = 0;
        stall_i <= 0;
      end else begin
        mode = ($time / 4000) % 3;
        if (mode == 0) stall_i <= 0;
        else if (mode == 1) stall_i <= ($urandom_range(0, 3) == 0);
        else stall_i <= ($urandom_range(0, 1) == 0);
      end
    end
  end

  task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
    valid_i <= 1;
    operation_i <= op;
    operand_a_i <= a;
    operand_b_i <= b;
    do @(posedge clk_i); while (stall_o);
    board.note_operation(op, a, b);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 3) - 1;
      3: return {{20{$urandom_range(0, 1) == 1}}, 12'($urandom)};
      4: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  localparam logic [31:0] DIR_VALS[6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                          32'h0000_0100, 32'hFFFF_FF00, 32'h0000_0080};

  initial begin
    int i, k, burst, gap;
    logic [31:0] a;
    @(posedge clk_i);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: every opcode over corner operands, division by zero, ties
    for (k = 0; k < 16; k++)
      send_op(k[3:0], DIR_VALS[k % 6], DIR_VALS[(k + 3) % 6]);
    send_op(OP_DIV, 32'h0000_0500, 32'h0);
    send_op(OP_DIV, 32'hFFFF_FB00, 32'h0);
    send_op(OP_DIV, 32'h0, 32'h0);
    send_op(OP_MIN, 32'h0000_1234, 32'h0000_1234);
    send_op(OP_MAX, 32'h8000_0000, 32'h8000_0000);
    send_op(OP_MUL, 32'h0000_0180, 32'hFFFF_FF80);
    send_op(OP_DIV, 32'h0000_0100, 32'h0000_0300);
    send_op(OP_DIV, 32'h8000_0000, 32'h0000_0001);
    i = 0;
    while (i < 1250) begin
      if (i == 400) long_hold = 1;
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && i < 1250; k++) begin
        a = pick_operand();
        send_op(4'($urandom_range(0, 15)), a,
                ($urandom_range(0, 7) == 0) ? a : pick_operand());
        i++;
      end
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
    end
    valid_i <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (board.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
